// ----- design/ccksb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccksb_pkg
// Shared types, codes and reset values for the chroma-key sprite blitter.
// ----------------------------------------------------------------------------
package ccksb_pkg;

	localparam int unsigned FRAME_WIDTH_DEF  = 512;
	localparam int unsigned FRAME_HEIGHT_DEF = 512;

	// Restoring division of a 13-bit dividend, one quotient bit per step.
	localparam int unsigned DIV_STEPS = 13;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		REG_DRAW_MODE   = 3'd0,
		REG_CHROMA_KEY  = 3'd1,
		REG_SUBST_COLOR = 3'd2,
		REG_BLEND_DIV   = 3'd3,
		REG_CLIP_LEFT   = 3'd4,
		REG_CLIP_RIGHT  = 3'd5,
		REG_CLIP_TOP    = 3'd6,
		REG_CLIP_BOTTOM = 3'd7
	} reg_index_t;

	localparam logic [2:0] MODE_ALPHA_COPY  = 3'd0;
	localparam logic [2:0] MODE_CHROMA_COPY = 3'd1;
	localparam logic [2:0] MODE_CHROMA_SUBST = 3'd2;
	localparam logic [2:0] MODE_CHROMA_GHOST = 3'd3;
	localparam logic [2:0] MODE_GHOST_ALL   = 3'd4;

	localparam logic [2:0]  DRAW_MODE_RST   = MODE_CHROMA_COPY;
	localparam logic [31:0] CHROMA_KEY_RST  = 32'd0;
	localparam logic [31:0] SUBST_COLOR_RST = 32'd0;
	localparam logic [7:0]  BLEND_DIV_RST   = 8'd32;
	localparam logic [7:0]  BLEND_DIV_MIN   = 8'd16;
	localparam logic [9:0]  CLIP_LEFT_RST   = 10'd0;
	localparam logic [9:0]  CLIP_RIGHT_RST  = 10'd512;
	localparam logic [9:0]  CLIP_TOP_RST    = 10'd0;
	localparam logic [9:0]  CLIP_BOTTOM_RST = 10'd512;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_GH_LOAD,
		ST_GH_DIV,
		ST_GH_WRITE,
		ST_RD_OUT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic gh_load;
		logic div_step;
		logic gh_write;
		logic load_out;
		logic clear_step;
	} ccksb_cmd_t;

	typedef struct packed {
		cmd_code_t kind;
		logic      ghost;
		logic      div_last;
		logic      clear_last;
		logic      out_busy;
	} ccksb_stat_t;

endpackage
`default_nettype wire

// ----- design/ccksb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccksb_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module ccksb_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ----- design/ccksb_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccksb_ctrl
// Sequencer: takes one word at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module ccksb_ctrl
	import ccksb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire ccksb_stat_t stat,
	output ccksb_cmd_t       cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				unique case (stat.kind)
					CMD_READ:  state_d = ST_RD_OUT;
					CMD_CLEAR: state_d = ST_CLEAR;
					default:   state_d = stat.ghost ? ST_GH_LOAD : ST_IDLE;
				endcase
			end
			ST_GH_LOAD:  state_d = ST_GH_DIV;
			ST_GH_DIV: begin
				if (stat.div_last) state_d = ST_GH_WRITE;
			end
			ST_GH_WRITE: state_d = ST_IDLE;
			ST_RD_OUT: begin
				if (!stat.out_busy) state_d = ST_IDLE;
			end
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EVAL:     cmd.eval       = 1'b1;
			ST_GH_LOAD:  cmd.gh_load    = 1'b1;
			ST_GH_DIV:   cmd.div_step   = 1'b1;
			ST_GH_WRITE: cmd.gh_write   = 1'b1;
			ST_RD_OUT:   cmd.load_out   = !stat.out_busy;
			ST_CLEAR:    cmd.clear_step = 1'b1;
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- design/ccksb_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccksb_dp
// Datapath: registers, sprite cursor, clip test, blend divider, frame store.
// ----------------------------------------------------------------------------
module ccksb_dp
	import ccksb_pkg::*;
#(
	parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ccksb_cmd_t  cmd,
	output ccksb_stat_t      stat,
	input  wire logic [1:0]  in_command,
	input  wire logic [10:0] in_pos_x,
	input  wire logic [10:0] in_pos_y,
	input  wire logic [9:0]  in_width,
	input  wire logic [9:0]  in_height,
	input  wire logic [31:0] in_color,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [31:0] out_color
);

	localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned SW    = $clog2(DIV_STEPS);

	// Configuration registers.
	logic [2:0]  draw_mode_q;
	logic [31:0] chroma_key_q, subst_color_q;
	logic [7:0]  blend_div_q;
	logic [9:0]  clip_left_q, clip_right_q, clip_top_q, clip_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_mode_q   <= DRAW_MODE_RST;
			chroma_key_q  <= CHROMA_KEY_RST;
			subst_color_q <= SUBST_COLOR_RST;
			blend_div_q   <= BLEND_DIV_RST;
			clip_left_q   <= CLIP_LEFT_RST;
			clip_right_q  <= CLIP_RIGHT_RST;
			clip_top_q    <= CLIP_TOP_RST;
			clip_bottom_q <= CLIP_BOTTOM_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_addr))
				REG_DRAW_MODE:   draw_mode_q   <= cfg_wdata[2:0];
				REG_CHROMA_KEY:  chroma_key_q  <= cfg_wdata;
				REG_SUBST_COLOR: subst_color_q <= cfg_wdata;
				REG_BLEND_DIV:   blend_div_q   <= cfg_wdata[7:0];
				REG_CLIP_LEFT:   clip_left_q   <= cfg_wdata[9:0];
				REG_CLIP_RIGHT:  clip_right_q  <= cfg_wdata[9:0];
				REG_CLIP_TOP:    clip_top_q    <= cfg_wdata[9:0];
				REG_CLIP_BOTTOM: clip_bottom_q <= cfg_wdata[9:0];
				default: begin
				end
			endcase
		end
	end

	// Captured word.
	cmd_code_t   kind_q;
	logic [10:0] pos_x_q, pos_y_q;
	logic [9:0]  width_q, height_q;
	logic [31:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= CMD_BEGIN;
		end else if (cmd.capture) begin
			kind_q <= cmd_code_t'(in_command);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_x_q  <= in_pos_x;
			pos_y_q  <= in_pos_y;
			width_q  <= in_width;
			height_q <= in_height;
			color_q  <= in_color;
		end
	end

	// Sprite state.
	logic signed [10:0] origin_col_q, origin_row_q;
	logic [9:0] span_cols_q, span_rows_q, cursor_col_q, cursor_row_q;
	logic [10:0] col_next;
	logic active;

	assign active   = (span_cols_q != 10'd0) && (cursor_row_q < span_rows_q);
	assign col_next = {1'b0, cursor_col_q} + 11'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_col_q <= '0;
			origin_row_q <= '0;
			span_cols_q  <= '0;
			span_rows_q  <= '0;
			cursor_col_q <= '0;
			cursor_row_q <= '0;
		end else if (cmd.eval) begin
			if (kind_q == CMD_BEGIN) begin
				origin_col_q <= pos_x_q;
				origin_row_q <= pos_y_q;
				span_cols_q  <= width_q;
				span_rows_q  <= height_q;
				cursor_col_q <= '0;
				cursor_row_q <= '0;
			end else if (kind_q == CMD_PIXEL && active) begin
				if (col_next >= {1'b0, span_cols_q}) begin
					cursor_col_q <= '0;
					cursor_row_q <= cursor_row_q + 10'd1;
				end else begin
					cursor_col_q <= col_next[9:0];
				end
			end
		end
	end

	// Destination spot and its tests.
	logic signed [11:0] col_s, row_s;
	logic in_frame, in_clip, pix_ok, keyed, direct, ghost;
	logic [AW-1:0] spot_addr;
	logic [31:0] direct_data;

	always_comb begin
		if (kind_q == CMD_READ) begin
			col_s = {pos_x_q[10], pos_x_q};
			row_s = {pos_y_q[10], pos_y_q};
		end else begin
			col_s = {origin_col_q[10], origin_col_q} + $signed({2'b00, cursor_col_q});
			row_s = {origin_row_q[10], origin_row_q} + $signed({2'b00, cursor_row_q});
		end
	end

	assign in_frame = (col_s >= 0) && (col_s < $signed(12'(FRAME_WIDTH)))
		&& (row_s >= 0) && (row_s < $signed(12'(FRAME_HEIGHT)));
	assign in_clip = (col_s >= $signed({2'b00, clip_left_q}))
		&& (col_s < $signed({2'b00, clip_right_q}))
		&& (row_s >= $signed({2'b00, clip_top_q}))
		&& (row_s < $signed({2'b00, clip_bottom_q}));
	assign spot_addr = AW'(AW'(row_s[10:0]) * AW'(FRAME_WIDTH) + AW'(col_s[10:0]));
	assign pix_ok = (kind_q == CMD_PIXEL) && active && in_frame && in_clip;
	assign keyed  = color_q != chroma_key_q;

	always_comb begin
		direct      = 1'b0;
		ghost       = 1'b0;
		direct_data = color_q;
		case (draw_mode_q)
			MODE_ALPHA_COPY:   direct = pix_ok && (color_q[31:24] != 8'd0);
			MODE_CHROMA_COPY:  direct = pix_ok && keyed;
			MODE_CHROMA_SUBST: begin
				direct      = pix_ok && keyed;
				direct_data = subst_color_q;
			end
			MODE_CHROMA_GHOST: ghost = pix_ok && keyed;
			MODE_GHOST_ALL:    ghost = pix_ok;
			default: begin
			end
		endcase
	end

	logic [AW-1:0] addr_q;
	logic rd_in_frame_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			addr_q        <= spot_addr;
			rd_in_frame_q <= in_frame;
		end
	end

	// Ghost blend: three channel lanes of a restoring divider.
	logic [7:0]  eff_div;
	logic [12:0] num_q [3];
	logic [7:0]  rem_q [3];
	logic [SW-1:0] step_q;
	logic [31:0] ram_rdata;
	logic [7:0]  sat [3];

	assign eff_div = (blend_div_q < BLEND_DIV_MIN) ? BLEND_DIV_MIN : blend_div_q;

	always_ff @(posedge clk) begin
		if (cmd.gh_load) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + SW'(1);
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_lane
		logic [8:0] sum;
		logic [8:0] trial;
		logic       fits;

		assign sum   = {1'b0, ram_rdata[8*i +: 8]} + {1'b0, color_q[8*i +: 8]};
		assign trial = {rem_q[i], num_q[i][12]};
		assign fits  = trial >= {1'b0, eff_div};
		assign sat[i] = (num_q[i][12:8] != 5'd0) ? 8'hFF : num_q[i][7:0];

		always_ff @(posedge clk) begin
			if (cmd.gh_load) begin
				num_q[i] <= {sum, 4'b0000};
				rem_q[i] <= '0;
			end else if (cmd.div_step) begin
				num_q[i] <= {num_q[i][11:0], fits};
				rem_q[i] <= fits ? 8'(trial - {1'b0, eff_div}) : trial[7:0];
			end
		end
	end

	// Clear sweep.
	logic [AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.eval) begin
			clr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// Frame store port.
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata;

	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_addr  = spot_addr;
		ram_wdata = direct_data;
		if (cmd.clear_step) begin
			ram_we    = 1'b1;
			ram_addr  = clr_q;
			ram_wdata = '0;
		end else if (cmd.gh_write) begin
			ram_we    = 1'b1;
			ram_addr  = addr_q;
			ram_wdata = {8'h00, sat[2], sat[1], sat[0]};
		end else if (cmd.eval) begin
			ram_we = direct;
			ram_re = ghost || ((kind_q == CMD_READ) && in_frame);
		end
	end

	ccksb_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_frame (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Result register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_color <= rd_in_frame_q ? ram_rdata : 32'd0;
		end
	end

	assign out_valid = out_valid_q;

	// The blend decision belongs to the word being evaluated only.
	assign stat.kind       = kind_q;
	assign stat.ghost      = ghost;
	assign stat.div_last   = step_q == SW'(DIV_STEPS - 1);
	assign stat.clear_last = clr_q == AW'(DEPTH - 1);
	assign stat.out_busy   = out_valid_q && !out_ready;

endmodule
`default_nettype wire

// ----- design/clipped_chroma_key_sprite_blitter.sv -----
`default_nettype none
// One word at a time. Begin and source-pixel words need only the evaluation step;
// a ghost-blended pixel also reads the frame store, takes 13 divider steps and writes back.
// A read word's result is loaded once the result register is free and held until taken.
// A clear word writes zero to every store entry, one store entry a cycle.
// Reset clears control, cursor and configuration registers; the frame store content
// is undefined until the first clear.
// ----------------------------------------------------------------------------
// clipped_chroma_key_sprite_blitter
// Top level: streaming sprite blitter with clipping and chroma keying over
// an on-chip frame store.
// ----------------------------------------------------------------------------
module clipped_chroma_key_sprite_blitter
	import ccksb_pkg::*;
#(
	parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
	parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// pos_x[10:0], pos_y[21:11], sprite_width[31:22], sprite_height[41:32],
	// pixel_color[73:42], zero fill[79:74]
	input  wire logic [79:0] s_axis_tdata,
	// command[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// read_color[31:0]
	output logic      [31:0] m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata
);

	// The controller and datapath speak only through these two bundles.
	ccksb_cmd_t  cmd;
	ccksb_stat_t stat;

	ccksb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	// The datapath captures the word on acceptance, so the handshake side is
	// free again as soon as the sequencer returns to idle.
	ccksb_dp #(
		.FRAME_WIDTH (FRAME_WIDTH),
		.FRAME_HEIGHT(FRAME_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_command(s_axis_tuser),
		.in_pos_x  (s_axis_tdata[10:0]),
		.in_pos_y  (s_axis_tdata[21:11]),
		.in_width  (s_axis_tdata[31:22]),
		.in_height (s_axis_tdata[41:32]),
		.in_color  (s_axis_tdata[73:42]),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_color (m_axis_tdata)
	);

endmodule
`default_nettype wire

// ----- design/ccksb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ccksb_checker
// Port-level checks on the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module ccksb_checker
	import ccksb_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready
);

	logic s_acc;
	assign s_acc = s_axis_tvalid && s_axis_tready;

	// A result once shown is held until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// One word at a time: the block is busy the cycle after acceptance.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_axis_tready)
		else $error("second word accepted while busy");

	// Only a read word produces a result.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && (s_axis_tuser != CMD_READ) && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result without a read word");

	// A read result cannot appear on the cycle straight after acceptance.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && !m_axis_tvalid |=> !m_axis_tvalid)
		else $error("result too early");

endmodule

bind clipped_chroma_key_sprite_blitter ccksb_checker u_ccksb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready)
);
`default_nettype wire

// ----- test/blit_checker.sv -----
// ----------------------------------------------------------------------------
// blit_checker
// Watches the word, result and configuration channels of the sprite blitter,
// keeps its own copy of the frame store and registers, and compares every
// read-back word with the colour it predicts.
// ----------------------------------------------------------------------------
module blit_checker
	import ccksb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,
	input  wire logic [1:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [31:0] cfg_wdata,
	output int               errors,
	output int               pending
);
	localparam int FW = 512;
	localparam int FH = 512;

	// Entries absent from the map hold zero; a clear simply empties it.
	logic [31:0] pixels [int];
	logic [31:0] colours_due [$];

	logic [2:0]  mode;
	logic [31:0] key, subst;
	logic [7:0]  divisor;
	logic [9:0]  clip_l, clip_r, clip_t, clip_b;
	int          org_col, org_row;
	int unsigned span_c, span_r, cur_c, cur_r;

	function automatic logic [31:0] stored(int idx);
		return pixels.exists(idx) ? pixels[idx] : 32'd0;
	endfunction

	function automatic logic [31:0] ghost_mix(logic [31:0] dst, logic [31:0] src);
		int unsigned dv;
		int unsigned q;
		logic [31:0] res;
		dv = (divisor < BLEND_DIV_MIN) ? 16 : divisor;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			q = ((dst[ch*8 +: 8] + src[ch*8 +: 8]) * 16) / dv;
			res[ch*8 +: 8] = (q > 255) ? 8'hFF : q[7:0];
		end
		return res;
	endfunction

	task automatic draw_pixel(logic [31:0] src);
		int col;
		int row;
		int idx;
		col = org_col + int'(cur_c);
		row = org_row + int'(cur_r);
		if (col < 0 || col >= FW || row < 0 || row >= FH) return;
		if (col < int'(clip_l) || col >= int'(clip_r)) return;
		if (row < int'(clip_t) || row >= int'(clip_b)) return;
		idx = row * FW + col;
		case (mode)
			MODE_ALPHA_COPY: if (src[31:24] != 0) pixels[idx] = src;
			MODE_CHROMA_COPY: if (src != key) pixels[idx] = src;
			MODE_CHROMA_SUBST: if (src != key) pixels[idx] = subst;
			MODE_CHROMA_GHOST: if (src != key) pixels[idx] = ghost_mix(stored(idx), src);
			MODE_GHOST_ALL: pixels[idx] = ghost_mix(stored(idx), src);
			default: ;
		endcase
	endtask

	task automatic apply_word(cmd_code_t cmd, logic [79:0] d);
		int px;
		int py;
		px = int'($signed(d[10:0]));
		py = int'($signed(d[21:11]));
		case (cmd)
			CMD_BEGIN: begin
				org_col = px;
				org_row = py;
				span_c = d[31:22];
				span_r = d[41:32];
				cur_c = 0;
				cur_r = 0;
			end
			CMD_PIXEL: begin
				if (span_c != 0 && cur_r < span_r) begin
					draw_pixel(d[73:42]);
					cur_c++;
					if (cur_c >= span_c) begin
						cur_c = 0;
						cur_r++;
					end
				end
			end
			CMD_READ: begin
				if (px >= 0 && px < FW && py >= 0 && py < FH)
					colours_due.insert(colours_due.size(), stored(py * FW + px));
				else
					colours_due.insert(colours_due.size(), 32'd0);
			end
			default: pixels.delete();
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = DRAW_MODE_RST;
			key = CHROMA_KEY_RST;
			subst = SUBST_COLOR_RST;
			divisor = BLEND_DIV_RST;
			clip_l = CLIP_LEFT_RST;
			clip_r = CLIP_RIGHT_RST;
			clip_t = CLIP_TOP_RST;
			clip_b = CLIP_BOTTOM_RST;
			org_col = 0;
			org_row = 0;
			span_c = 0;
			span_r = 0;
			cur_c = 0;
			cur_r = 0;
			errors = 0;
			colours_due.delete();
			pixels.delete();
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_addr))
					REG_DRAW_MODE: mode = cfg_wdata[2:0];
					REG_CHROMA_KEY: key = cfg_wdata;
					REG_SUBST_COLOR: subst = cfg_wdata;
					REG_BLEND_DIV: divisor = cfg_wdata[7:0];
					REG_CLIP_LEFT: clip_l = cfg_wdata[9:0];
					REG_CLIP_RIGHT: clip_r = cfg_wdata[9:0];
					REG_CLIP_TOP: clip_t = cfg_wdata[9:0];
					default: clip_b = cfg_wdata[9:0];
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (colours_due.size() == 0) begin
					$display("%0t: read word with none due, got %h", $time, m_axis_tdata);
					errors++;
				end else begin
					if (m_axis_tdata !== colours_due[0]) begin
						$display("%0t: read_color expected %h got %h", $time,
							colours_due[0], m_axis_tdata);
						errors++;
					end
					void'(colours_due.pop_front());
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				apply_word(cmd_code_t'(s_axis_tuser), s_axis_tdata);
		end
		pending = colours_due.size();
	end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the chroma-key sprite blitter: clears the frame store, runs a
// short directed set of sprites and reads, then random configurations with
// small sprites drawn near the frame and clip edges, read back through the
// result channel. Checking is left to blit_checker.
// ----------------------------------------------------------------------------
module tb;
	import ccksb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// pos_x, pos_y, sprite_width, sprite_height, pixel_color, zero fill
	logic [79:0] s_axis_tdata;
	// command
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// read_color
	logic [31:0] m_axis_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_wdata;
	int          errors;
	int          pending;

	// A clear walks every store entry without accepting anything, so the
	// watchdog must outlast one clear several times over.
	localparam int STALL_LIMIT = 1200000;

	int          words_sent;
	int          reads_sent;
	int          quiet_cycles;
	bit          bursty;
	bit          hold_request;
	int          last_x, last_y;
	logic [31:0] key_now;

	clipped_chroma_key_sprite_blitter dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	blit_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one; a bursty phase has none.
	function automatic int gap_length();
		int r;
		r = $urandom_range(99);
		if (bursty || r < 55) return 0;
		if (r < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 5);
	endfunction

	// Result side. A hold request makes it refuse results for a long
	// stretch so that the blitter backs up and stops taking new words.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			if (bursty)
				m_axis_tready <= 1'b1;
			else if ($urandom_range(99) < 8)
				m_axis_tready <= 1'b0;
			else if ($urandom_range(99) < 3) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(30, 5)) @(negedge clk);
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// Offers one word and returns at the falling edge after it was taken.
	// The valid is left high, so it stays asserted between back-to-back words.
	task automatic send_word(cmd_code_t cmd, int x, int y, int w, int h, logic [31:0] colour);
		int gap;
		gap = gap_length();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {6'd0, colour, h[9:0], w[9:0], y[10:0], x[10:0]};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		words_sent++;
		if (cmd == CMD_READ) reads_sent++;
	endtask

	task automatic read_at(int x, int y);
		send_word(CMD_READ, x, y, 0, 0, 32'd0);
	endtask

	task automatic begin_sprite(int x, int y, int w, int h);
		send_word(CMD_BEGIN, x, y, w, h, $urandom());
		last_x = x;
		last_y = y;
	endtask

	task automatic pixel(logic [31:0] colour);
		send_word(CMD_PIXEL, $urandom_range(2047), $urandom_range(2047),
			$urandom_range(1023), $urandom_range(1023), colour);
	endtask

	// Registers change only with nothing in flight. A clear is always followed
	// by a read here, so waiting for the reads covers it; the longest other
	// word is a ghost blend through the divider, so a short pause covers the rest.
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (24) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CHROMA_KEY) key_now = value;
	endtask

	function automatic logic [31:0] source_colour();
		int r;
		r = $urandom_range(99);
		if (r < 25) return key_now;
		if (r < 35) return {8'h00, 24'($urandom())};
		if (r < 45) return {8'hFF, 24'($urandom())};
		return $urandom();
	endfunction

	function automatic int edge_coord();
		case ($urandom_range(5))
			0: return $urandom_range(6) - 8;
			1: return 505 + $urandom_range(9);
			2: return $urandom_range(2047) - 1024;
			default: return $urandom_range(511);
		endcase
	endfunction

	function automatic int clip_bound();
		case ($urandom_range(4))
			0: return 0;
			1: return 512;
			2: return $urandom_range(1023);
			default: return $urandom_range(511);
		endcase
	endfunction

	initial begin
		int w;
		int h;
		int n;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_BEGIN;
		cfg_we = 1'b0;
		cfg_addr = REG_DRAW_MODE;
		cfg_wdata = '0;
		words_sent = 0;
		reads_sent = 0;
		quiet_cycles = 0;
		bursty = 1'b0;
		hold_request = 1'b0;
		key_now = CHROMA_KEY_RST;
		last_x = 0;
		last_y = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The store holds nothing defined until cleared. A sprite begun now
		// must survive the clear: the cursor is kept across it.
		begin_sprite(-2, -1, 4, 3);
		pixel(32'h11223344);
		send_word(CMD_CLEAR, 0, 0, 0, 0, 32'd0);
		read_at(0, 0);
		repeat (10) pixel(source_colour());
		pixel(32'hDEADBEEF);
		for (int i = 0; i < 3; i++) read_at(i, 0);
		read_at(-1, 0);
		read_at(512, 0);
		read_at(0, 1023);
		read_at(-1024, -1024);

		// Alpha copy: alpha zero is transparent.
		write_reg(REG_DRAW_MODE, MODE_ALPHA_COPY);
		begin_sprite(510, 511, 3, 1);
		pixel(32'h00FFFFFF);
		pixel(32'hFF123456);
		pixel(32'hFFFFFFFF);
		read_at(510, 511);
		read_at(511, 511);

		// Substitute colour and a chroma key with every bit set.
		write_reg(REG_DRAW_MODE, MODE_CHROMA_SUBST);
		write_reg(REG_SUBST_COLOR, 32'hFFFFFFFF);
		write_reg(REG_CHROMA_KEY, 32'hFFFFFFFF);
		begin_sprite(1023, 1023, 1023, 1023);
		pixel(32'h0);
		begin_sprite(5, 5, 2, 1);
		pixel(32'hFFFFFFFF);
		pixel(32'h00000001);
		read_at(5, 5);
		read_at(6, 5);

		// Ghost blend with the divisor below one and at its largest.
		write_reg(REG_DRAW_MODE, MODE_GHOST_ALL);
		write_reg(REG_BLEND_DIV, 8'd0);
		begin_sprite(6, 5, 1, 1);
		pixel(32'hFFFFFFFF);
		read_at(6, 5);
		write_reg(REG_DRAW_MODE, MODE_CHROMA_GHOST);
		write_reg(REG_BLEND_DIV, 8'd255);
		begin_sprite(5, 5, 2, 1);
		pixel(32'hFFFFFFFF);
		pixel(32'h80FF7F01);
		read_at(6, 5);

		// An unused mode and an empty clip draw nothing; zero width ignores pixels.
		write_reg(REG_DRAW_MODE, 3'd7);
		begin_sprite(0, 0, 1, 1);
		pixel(32'hCAFEF00D);
		read_at(0, 0);
		write_reg(REG_DRAW_MODE, MODE_CHROMA_COPY);
		write_reg(REG_CLIP_LEFT, 10'd512);
		write_reg(REG_CLIP_RIGHT, 10'd0);
		write_reg(REG_CLIP_TOP, 10'd1023);
		write_reg(REG_CLIP_BOTTOM, 10'd0);
		begin_sprite(0, 0, 1, 1);
		pixel(32'h12345678);
		begin_sprite(0, 0, 0, 5);
		pixel(32'h12345678);
		read_at(0, 0);

		// Long hold-off on the result side while reads keep coming.
		hold_request = 1'b1;
		for (int i = 0; i < 8; i++) read_at(i, 0);

		// Random phases: new settings, then small sprites near the edges.
		for (int phase = 0; words_sent < 1450; phase++) begin
			bursty = (phase % 4 == 3);
			write_reg(REG_DRAW_MODE, (phase < 8) ? phase[2:0] :
				(($urandom_range(9) == 0) ? $urandom_range(7, 5) : $urandom_range(4)));
			write_reg(REG_CHROMA_KEY, $urandom());
			write_reg(REG_SUBST_COLOR, $urandom());
			write_reg(REG_BLEND_DIV, ($urandom_range(3) == 0) ? $urandom_range(255)
				: $urandom_range(255, 16));
			if ($urandom_range(3) == 0) begin
				write_reg(REG_CLIP_LEFT, 0);
				write_reg(REG_CLIP_RIGHT, 512);
				write_reg(REG_CLIP_TOP, 0);
				write_reg(REG_CLIP_BOTTOM, 512);
			end else begin
				write_reg(REG_CLIP_LEFT, clip_bound());
				write_reg(REG_CLIP_RIGHT, clip_bound());
				write_reg(REG_CLIP_TOP, clip_bound());
				write_reg(REG_CLIP_BOTTOM, clip_bound());
			end
			for (int s = 0; s < 8 && words_sent < 1450; s++) begin
				if ($urandom_range(19) == 0) begin
					w = $urandom_range(1023);
					h = $urandom_range(1023);
				end else begin
					w = $urandom_range(8, 1);
					h = $urandom_range(6, 1);
				end
				begin_sprite(edge_coord(), edge_coord(), w, h);
				n = (w * h > 48) ? 12 : w * h + (($urandom_range(4) == 0) ? 2 : 0);
				for (int p = 0; p < n; p++) begin
					pixel(source_colour());
					if ($urandom_range(9) == 0)
						read_at(last_x + $urandom_range(8), last_y + $urandom_range(6));
				end
				repeat ($urandom_range(4, 1))
					read_at(last_x + $urandom_range(8), last_y + $urandom_range(6));
				if ($urandom_range(9) == 0)
					read_at($urandom_range(2047) - 1024, $urandom_range(2047) - 1024);
			end
			// One more clear midway through, checked by the reads that follow.
			if (phase == 6) begin
				send_word(CMD_CLEAR, 0, 0, 0, 0, 32'd0);
				read_at(last_x, last_y);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		$display("Sent %0d words, %0d of them reads, over all eight draw modes,", words_sent,
			reads_sent);
		$display("edge and empty clip windows, two clears and a long result hold-off.");
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/ccksb_pkg.sv
design/ccksb_ram.sv
design/ccksb_ctrl.sv
design/ccksb_dp.sv
design/clipped_chroma_key_sprite_blitter.sv
design/ccksb_checker.sv
test/blit_checker.sv
test/tb.sv
